// File: rtl/psd_pkg.sv
// shared types and constants for the polygon signed distance unit
package psd_pkg;

	// opcodes of a request beat
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// fixed port widths
	localparam int VC_W    = 5;
	localparam int IDXP_W  = 4;
	localparam int COORD_W = 32;
	localparam int DIST_W  = 34;
	localparam int DMAG_W  = DIST_W - 1;

	// quotient width that still maps onto an unsaturated distance
	localparam int QW     = 2 * DMAG_W;
	localparam int STEP_W = $clog2(QW + 1);

	localparam logic [DMAG_W-1:0] DIST_SAT = {DMAG_W{1'b1}};
	localparam logic [VC_W-1:0]   VC_RESET = VC_W'(3);

	typedef struct packed {
		logic                       op;
		logic [IDXP_W-1:0]          vertex_index;
		logic signed [COORD_W-1:0]  coord_x;
		logic signed [COORD_W-1:0]  coord_y;
	} psd_req_t;

	typedef struct packed {
		logic signed [DIST_W-1:0]   signed_distance;
		logic                       inside_res;
	} psd_rsp_t;

endpackage

// File: rtl/polygon_signed_distance_unit.sv
// polygon signed distance: vertex store, shared multiplier, divider and root sequencer
// a load beat writes the vertex store while idle; a query walks each edge on the endpoint path
// (nearest point at a segment end) or the divider path (nearest point inside a segment), using
// one shared multiplier, a one-bit-per-cycle divider and a two-bits-per-cycle square root
// the result beat is registered once the last edge is done; the next beat can enter once the
// unit is back in idle, and a result still waiting holds the next query at its last step
// asynchronous active-low reset clears control state; vertex_count resets to 3; no store reset
module polygon_signed_distance_unit import psd_pkg::*; #(
	parameter int MAX_VERTICES = 16,
	parameter int COORD_WIDTH  = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [VC_W-1:0] cfg_data,
	input  logic            req_valid,
	output logic            req_stall,
	input  psd_req_t        req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output psd_rsp_t        rsp
);

	localparam int CW    = COORD_WIDTH;
	localparam int DW    = CW + 1;
	localparam int MW    = DW + 1;
	localparam int PW    = 2 * MW;
	localparam int AW    = PW + 1;
	localparam int RW    = 2 * DW;
	localparam int SW    = 4 * DW;
	localparam int XW0   = RW + QW;
	localparam int XW    = (SW > XW0) ? SW : XW0;
	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_READ, S_DIFF, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_MW, S_CLS,
		S_E1, S_E2, S_E3, S_E4, S_C1, S_C2, S_C3, S_C4, S_C5, S_DIV, S_SQI, S_SQ,
		S_UPD, S_OUT
	} state_t;

	typedef enum logic [3:0] {
		A_NONE, A_CR_LD, A_CR_SUB, A_DOT_LD, A_DOT_ADD, A_AB_LD, A_AB_ADD,
		A_S_LD, A_S_ADD, A_S_MID, A_S_HI
	} acc_op_t;

	state_t                    state_q;
	acc_op_t                   op_q, op_d;
	logic [VC_W-1:0]           vc_q;
	logic [CNT_W-1:0]          n_q, n_w;
	logic [IDX_W-1:0]          v_q, ia;
	logic signed [CW-1:0]      mem_x [MAX_VERTICES];
	logic signed [CW-1:0]      mem_y [MAX_VERTICES];
	logic signed [CW-1:0]      ax_q, ay_q, bx_q, by_q, px_q, py_q;
	logic signed [DW-1:0]      abx_q, aby_q, apx_q, apy_q, bpx_q, bpy_q;
	logic                      a_le_q, b_gt_q, use_b_q;
	logic signed [MW-1:0]      ma, mb;
	logic signed [PW-1:0]      prod_q;
	logic [RW-1:0]             pu;
	logic signed [AW-1:0]      cr_q, dot_q, ab2_q;
	logic [RW-1:0]             ab2u, cm_q;
	logic [SW-1:0]             s_q;
	logic [RW-1:0]             rem_q;
	logic [RW:0]               div_t;
	logic                      div_ge;
	logic [QW-1:0]             qlo_q, x_q, res_q, bit_q, rb, res_n;
	logic [STEP_W-1:0]         cnt_q;
	logic [DMAG_W-1:0]         dist_q, best_q;
	logic signed [CNT_W:0]     wind_q;
	logic                      rsp_valid_q;
	logic                      out_fire;
	psd_rsp_t                  rsp_q;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// result register free for a new beat
	assign out_fire = (state_q == S_OUT) && (!rsp_valid_q || !rsp_stall);

	// clamp the configured vertex count
	assign n_w = (32'(vc_q) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : CNT_W'(vc_q);
	assign ia  = (v_q == '0) ? IDX_W'(n_q - CNT_W'(1)) : IDX_W'(v_q - IDX_W'(1));

	// vertex store
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid && req.op == OP_LOAD &&
		    32'(req.vertex_index) < MAX_VERTICES) begin
			mem_x[IDX_W'(req.vertex_index)] <= CW'(req.coord_x);
			mem_y[IDX_W'(req.vertex_index)] <= CW'(req.coord_y);
		end
		if (state_q == S_READ) begin
			ax_q <= mem_x[ia];
			ay_q <= mem_y[ia];
			bx_q <= mem_x[v_q];
			by_q <= mem_y[v_q];
		end
	end

	// shared multiplier operand select
	always_comb begin
		ma   = '0;
		mb   = '0;
		op_d = A_NONE;
		unique case (state_q)
			S_M1: begin ma = MW'(abx_q); mb = MW'(apy_q); op_d = A_CR_LD; end
			S_M2: begin ma = MW'(aby_q); mb = MW'(apx_q); op_d = A_CR_SUB; end
			S_M3: begin ma = MW'(abx_q); mb = MW'(apx_q); op_d = A_DOT_LD; end
			S_M4: begin ma = MW'(aby_q); mb = MW'(apy_q); op_d = A_DOT_ADD; end
			S_M5: begin ma = MW'(abx_q); mb = MW'(abx_q); op_d = A_AB_LD; end
			S_M6: begin ma = MW'(aby_q); mb = MW'(aby_q); op_d = A_AB_ADD; end
			S_E1: begin
				ma   = use_b_q ? MW'(bpx_q) : MW'(apx_q);
				mb   = ma;
				op_d = A_S_LD;
			end
			S_E2: begin
				ma   = use_b_q ? MW'(bpy_q) : MW'(apy_q);
				mb   = ma;
				op_d = A_S_ADD;
			end
			S_C1: begin
				ma = signed'({1'b0, cm_q[DW-1:0]}); mb = ma; op_d = A_S_LD;
			end
			S_C2: begin
				ma = signed'({1'b0, cm_q[RW-1:DW]}); mb = signed'({1'b0, cm_q[DW-1:0]});
				op_d = A_S_MID;
			end
			S_C3: begin
				ma = signed'({1'b0, cm_q[RW-1:DW]}); mb = ma; op_d = A_S_HI;
			end
			default: begin
				ma   = '0;
				mb   = '0;
				op_d = A_NONE;
			end
		endcase
	end

	assign pu   = prod_q[RW-1:0];
	assign ab2u = ab2_q[RW-1:0];

	// divider step and root step
	assign div_t  = {rem_q, qlo_q[QW-1]};
	assign div_ge = (div_t >= {1'b0, ab2u});
	assign rb     = res_q + bit_q;
	assign res_n  = (x_q >= rb) ? ((res_q >> 1) + bit_q) : (res_q >> 1);

	// sequencer, datapath and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= A_NONE;
			vc_q        <= VC_RESET;
			rsp_valid_q <= 1'b0;
			n_q         <= '0;
			v_q         <= '0;
			cnt_q       <= '0;
			wind_q      <= '0;
			best_q      <= DIST_SAT;
		end else begin
			if (cfg_we) begin
				vc_q <= cfg_data;
			end
			if (out_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			// product register and accumulation
			prod_q <= ma * mb;
			op_q   <= op_d;
			unique case (op_q)
				A_CR_LD:   cr_q  <= AW'(prod_q);
				A_CR_SUB:  cr_q  <= cr_q - AW'(prod_q);
				A_DOT_LD:  dot_q <= AW'(prod_q);
				A_DOT_ADD: dot_q <= dot_q + AW'(prod_q);
				A_AB_LD:   ab2_q <= AW'(prod_q);
				A_AB_ADD:  ab2_q <= ab2_q + AW'(prod_q);
				A_S_LD:    s_q   <= SW'(pu);
				A_S_ADD:   s_q   <= s_q + SW'(pu);
				A_S_MID:   s_q   <= s_q + (SW'(pu) << (DW + 1));
				A_S_HI:    s_q   <= s_q + (SW'(pu) << RW);
				default:   ;
			endcase

			unique case (state_q)
				S_IDLE: begin
					if (req_valid && req.op == OP_QUERY) begin
						px_q   <= CW'(req.coord_x);
						py_q   <= CW'(req.coord_y);
						n_q    <= n_w;
						v_q    <= '0;
						wind_q <= '0;
						best_q <= DIST_SAT;
						state_q <= (n_w == '0) ? S_OUT : S_READ;
					end
				end
				S_READ: state_q <= S_DIFF;
				S_DIFF: begin
					abx_q  <= DW'(bx_q) - DW'(ax_q);
					aby_q  <= DW'(by_q) - DW'(ay_q);
					apx_q  <= DW'(px_q) - DW'(ax_q);
					apy_q  <= DW'(py_q) - DW'(ay_q);
					bpx_q  <= DW'(px_q) - DW'(bx_q);
					bpy_q  <= DW'(py_q) - DW'(by_q);
					a_le_q <= (ay_q <= py_q);
					b_gt_q <= (by_q > py_q);
					state_q <= S_M1;
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_M4;
				S_M4: state_q <= S_M5;
				S_M5: state_q <= S_M6;
				S_M6: state_q <= S_MW;
				S_MW: state_q <= S_CLS;
				// crossing count and nearest-point class
				S_CLS: begin
					if (a_le_q) begin
						if (b_gt_q && cr_q > 0) begin
							wind_q <= wind_q + (CNT_W + 1)'(1);
						end
					end else if (!b_gt_q && cr_q < 0) begin
						wind_q <= wind_q - (CNT_W + 1)'(1);
					end
					cm_q <= (cr_q < 0) ? RW'(-cr_q) : RW'(cr_q);
					priority if (dot_q <= 0) begin
						use_b_q <= 1'b0;
						state_q <= S_E1;
					end else if (dot_q >= ab2_q) begin
						use_b_q <= 1'b1;
						state_q <= S_E1;
					end else begin
						state_q <= S_C1;
					end
				end
				S_E1: state_q <= S_E2;
				S_E2: state_q <= S_E3;
				S_E3: state_q <= S_E4;
				S_E4: begin
					if (s_q >= (SW'(1) << QW)) begin
						dist_q  <= DIST_SAT;
						state_q <= S_UPD;
					end else begin
						qlo_q   <= s_q[QW-1:0];
						state_q <= S_SQI;
					end
				end
				S_C1: state_q <= S_C2;
				S_C2: state_q <= S_C3;
				S_C3: state_q <= S_C4;
				S_C4: state_q <= S_C5;
				// cross squared over edge length squared, saturated up front
				S_C5: begin
					if (XW'(s_q) >= (XW'(ab2u) << QW)) begin
						dist_q  <= DIST_SAT;
						state_q <= S_UPD;
					end else begin
						rem_q   <= RW'(s_q >> QW);
						qlo_q   <= s_q[QW-1:0];
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= div_ge ? RW'(div_t - {1'b0, ab2u}) : div_t[RW-1:0];
					qlo_q <= {qlo_q[QW-2:0], div_ge};
					cnt_q <= cnt_q + STEP_W'(1);
					if (cnt_q == STEP_W'(QW - 1)) begin
						state_q <= S_SQI;
					end
				end
				S_SQI: begin
					x_q     <= qlo_q;
					res_q   <= '0;
					bit_q   <= QW'(1) << (QW - 2);
					cnt_q   <= '0;
					state_q <= S_SQ;
				end
				// integer square root, two bits per cycle
				S_SQ: begin
					if (x_q >= rb) begin
						x_q <= x_q - rb;
					end
					res_q <= res_n;
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q + STEP_W'(1);
					if (cnt_q == STEP_W'(QW / 2 - 1)) begin
						dist_q  <= DMAG_W'(res_n);
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (dist_q < best_q) begin
						best_q <= dist_q;
					end
					v_q <= v_q + IDX_W'(1);
					state_q <= ((CNT_W'(v_q) + CNT_W'(1)) == n_q) ? S_OUT : S_READ;
				end
				// result beat
				S_OUT: begin
					if (out_fire) begin
						rsp_q.inside_res <= (wind_q != '0);
						rsp_q.signed_distance <= (wind_q != '0) ?
							-signed'({1'b0, best_q}) : signed'({1'b0, best_q});
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// divider remainder stays below the edge length squared
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < ab2u)
		else $error("divider remainder out of range");

	// edge length squared is never negative
	a_ab2_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLS |-> !ab2_q[AW-1])
		else $error("negative edge length squared");

	// an outside result never carries a negative distance
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.inside_res |-> !rsp_q.signed_distance[DIST_W-1])
		else $error("outside result with negative distance");

	// a query result appears only after a walk ends
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result beat without finished walk");

endmodule
